@@ hw/rtl/tri_pkg.sv @@
// ----------------------------------------------------------------------------
// tri_pkg
// Shared types and constants of the triangle edge rasterizer.
// ----------------------------------------------------------------------------
package tri_pkg;

	localparam int SHIFT_BITS  = 11;   // drawing offset width
	localparam int COL_BITS    = 10;   // frame-buffer column width
	localparam int ROW_BITS    = 9;    // frame-buffer row width
	localparam int ATTR_BITS   = 8;    // one colour / texture component
	localparam int NUM_ATTRS   = 5;    // red, green, blue, u, v
	localparam int NUM_CORNERS = 3;

	localparam int ATTR_RED   = 0;
	localparam int ATTR_GREEN = 1;
	localparam int ATTR_BLUE  = 2;
	localparam int ATTR_TEX_U = 3;
	localparam int ATTR_TEX_V = 4;

	typedef logic [NUM_ATTRS-1:0][ATTR_BITS-1:0] attr_t;

	typedef struct packed {
		logic        [COL_BITS-1:0]   left;
		logic        [COL_BITS-1:0]   right;
		logic        [ROW_BITS-1:0]   top;
		logic        [ROW_BITS-1:0]   bottom;
		logic signed [SHIFT_BITS-1:0] shift_x;
		logic signed [SHIFT_BITS-1:0] shift_y;
	} clip_cfg_t;

	typedef struct packed {
		logic [COL_BITS-1:0] min_col;
		logic [COL_BITS-1:0] max_col;
		logic [ROW_BITS-1:0] min_row;
		logic [ROW_BITS-1:0] max_row;
	} box_t;

endpackage

@@ hw/rtl/tri_lane.sv @@
// ----------------------------------------------------------------------------
// tri_lane
// One attribute lane: bit-serial weighted sum, then radix-2 division by area.
// ----------------------------------------------------------------------------
module tri_lane #(
	parameter int WEIGHT_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tri_pkg::ATTR_BITS-1:0]  a0,
	input  logic [tri_pkg::ATTR_BITS-1:0]  a1,
	input  logic [tri_pkg::ATTR_BITS-1:0]  a2,
	input  logic [WEIGHT_BITS-1:0]         w0,
	input  logic [WEIGHT_BITS-1:0]         w1,
	input  logic [WEIGHT_BITS-1:0]         w2,
	input  logic [WEIGHT_BITS-1:0]         area,
	output logic [tri_pkg::ATTR_BITS-1:0]  quot,
	output logic                           done
);
	import tri_pkg::*;

	localparam int NW = WEIGHT_BITS + ATTR_BITS + 2;   // three weighted terms
	localparam int CB = $clog2(ATTR_BITS);
	localparam logic [CB-1:0] LAST_STEP = CB'(ATTR_BITS - 1);

	logic                  busy_q, div_q, done_q;
	logic [CB-1:0]         cnt_q;
	logic [ATTR_BITS-1:0]  a0_q, a1_q, a2_q, q_q;
	logic [WEIGHT_BITS-1:0] w0_q, w1_q, w2_q;
	logic [NW-1:0]         acc_q, d_q;

	logic [NW-1:0] mac_next;
	logic          ge;

	// MSB-first shift-add over the attribute bits
	assign mac_next = {acc_q[NW-2:0], 1'b0}
		+ NW'(a0_q[ATTR_BITS-1] ? w0_q : '0)
		+ NW'(a1_q[ATTR_BITS-1] ? w1_q : '0)
		+ NW'(a2_q[ATTR_BITS-1] ? w2_q : '0);
	assign ge = (acc_q >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && div_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				div_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					if (div_q)
						busy_q <= 1'b0;
					div_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a0_q  <= a0;
			a1_q  <= a1;
			a2_q  <= a2;
			w0_q  <= w0;
			w1_q  <= w1;
			w2_q  <= w2;
			acc_q <= '0;
		end else if (busy_q) begin
			if (!div_q) begin
				acc_q <= mac_next;
				a0_q  <= {a0_q[ATTR_BITS-2:0], 1'b0};
				a1_q  <= {a1_q[ATTR_BITS-2:0], 1'b0};
				a2_q  <= {a2_q[ATTR_BITS-2:0], 1'b0};
				if (cnt_q == LAST_STEP)
					d_q <= NW'(area) << (ATTR_BITS - 1);
			end else begin
				// restoring step, one quotient bit per cycle
				if (ge)
					acc_q <= acc_q - d_q;
				q_q <= {q_q[ATTR_BITS-2:0], ge};
				d_q <= d_q >> 1;
			end
		end
	end

	assign quot = q_q;
	assign done = done_q;

endmodule

@@ hw/rtl/tri_setup.sv @@
// ----------------------------------------------------------------------------
// tri_setup
// Triangle setup: offset corners, clipped box, area, start edge weights and steps.
// ----------------------------------------------------------------------------
module tri_setup #(
	parameter int COORD_BITS  = 11,
	parameter int WEIGHT_BITS = 48,
	localparam int CW = ((COORD_BITS > tri_pkg::SHIFT_BITS) ? COORD_BITS
		: tri_pkg::SHIFT_BITS) + 1,
	localparam int DW = CW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_BITS-1:0]  cx [3],
	input  logic signed [COORD_BITS-1:0]  cy [3],
	input  tri_pkg::clip_cfg_t            cfg,
	output logic                          done,
	output logic signed [WEIGHT_BITS-1:0] area,
	output tri_pkg::box_t                 box,
	output logic signed [WEIGHT_BITS-1:0] row_w [3],
	output logic signed [DW-1:0]          dx [3],
	output logic signed [DW-1:0]          dy [3]
);
	import tri_pkg::*;

	localparam int PW = 2 * DW;
	localparam int WB = WEIGHT_BITS;

	typedef enum logic [2:0] {SU_IDLE, SU_SHIFT, SU_BOX, SU_MUL, SU_SUB} su_state_t;

	su_state_t           state_q;
	logic [1:0]          job_q;
	logic                done_q;
	logic signed [CW-1:0] sx_q [3];
	logic signed [CW-1:0] sy_q [3];
	box_t                box_q;
	logic signed [PW-1:0] prod1_q, prod2_q;
	logic signed [WB-1:0] area_q;
	logic signed [WB-1:0] row_w_q [3];
	logic signed [DW-1:0] dx_q [3];
	logic signed [DW-1:0] dy_q [3];

	logic signed [CW-1:0] ax, ay, bx, by, px, py;
	logic signed [CW-1:0] rax, ray, rbx, rby;
	logic signed [CW-1:0] mnx, mxx, mny, mxy;
	logic signed [DW-1:0] dbx, dby, dpx, dpy;
	logic signed [WB-1:0] edge_w;
	logic [1:0]           ej;
	logic                 swap;

	function automatic logic signed [CW-1:0] clamp_c(
		input logic signed [CW-1:0] v,
		input logic signed [CW-1:0] lo,
		input logic signed [CW-1:0] hi
	);
		logic signed [CW-1:0] r;
		r = v;
		if (v < lo)
			r = lo;
		else if (v > hi)
			r = hi;
		return r;
	endfunction

	function automatic logic signed [CW-1:0] min3(
		input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b,
		input logic signed [CW-1:0] c
	);
		logic signed [CW-1:0] m;
		m = a;
		if (b < m) m = b;
		if (c < m) m = c;
		return m;
	endfunction

	function automatic logic signed [CW-1:0] max3(
		input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b,
		input logic signed [CW-1:0] c
	);
		logic signed [CW-1:0] m;
		m = a;
		if (b > m) m = b;
		if (c > m) m = c;
		return m;
	endfunction

	assign mnx = min3(sx_q[0], sx_q[1], sx_q[2]);
	assign mxx = max3(sx_q[0], sx_q[1], sx_q[2]);
	assign mny = min3(sy_q[0], sy_q[1], sy_q[2]);
	assign mxy = max3(sy_q[0], sy_q[1], sy_q[2]);

	// clockwise triangles swap the roles of corners 0 and 1
	assign swap = area_q[WB-1];
	assign rax  = swap ? sx_q[1] : sx_q[0];
	assign ray  = swap ? sy_q[1] : sy_q[0];
	assign rbx  = swap ? sx_q[0] : sx_q[1];
	assign rby  = swap ? sy_q[0] : sy_q[1];

	always_comb begin
		px = signed'(CW'(box_q.min_col));
		py = signed'(CW'(box_q.min_row));
		case (job_q)
			2'd0: begin
				ax = sx_q[0]; ay = sy_q[0];
				bx = sx_q[1]; by = sy_q[1];
				px = sx_q[2]; py = sy_q[2];
			end
			2'd1: begin
				ax = rax; ay = ray;
				bx = rbx; by = rby;
			end
			2'd2: begin
				ax = rbx; ay = rby;
				bx = sx_q[2]; by = sy_q[2];
			end
			default: begin
				ax = sx_q[2]; ay = sy_q[2];
				bx = rax; by = ray;
			end
		endcase
	end

	assign dbx    = DW'(bx) - DW'(ax);
	assign dby    = DW'(by) - DW'(ay);
	assign dpx    = DW'(px) - DW'(ax);
	assign dpy    = DW'(py) - DW'(ay);
	assign edge_w = WB'(prod1_q) - WB'(prod2_q);
	assign ej     = job_q - 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_IDLE;
			job_q   <= '0;
			done_q  <= 1'b0;
			area_q  <= '0;
			box_q   <= '0;
			prod1_q <= '0;
			prod2_q <= '0;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				sx_q[i]    <= '0;
				sy_q[i]    <= '0;
				row_w_q[i] <= '0;
				dx_q[i]    <= '0;
				dy_q[i]    <= '0;
			end
		end else begin
			done_q <= (state_q == SU_SUB) && (job_q == 2'd3);
			case (state_q)
				SU_IDLE: begin
					if (start)
						state_q <= SU_SHIFT;
				end
				SU_SHIFT: begin
					for (int i = 0; i < NUM_CORNERS; i++) begin
						sx_q[i] <= CW'(cx[i]) + CW'(cfg.shift_x);
						sy_q[i] <= CW'(cy[i]) + CW'(cfg.shift_y);
					end
					state_q <= SU_BOX;
				end
				SU_BOX: begin
					box_q.min_col <= COL_BITS'(clamp_c(mnx, signed'(CW'(cfg.left)),
						signed'(CW'(cfg.right))));
					box_q.max_col <= COL_BITS'(clamp_c(mxx, signed'(CW'(cfg.left)),
						signed'(CW'(cfg.right))));
					box_q.min_row <= ROW_BITS'(clamp_c(mny, signed'(CW'(cfg.top)),
						signed'(CW'(cfg.bottom))));
					box_q.max_row <= ROW_BITS'(clamp_c(mxy, signed'(CW'(cfg.top)),
						signed'(CW'(cfg.bottom))));
					job_q   <= '0;
					state_q <= SU_MUL;
				end
				SU_MUL: begin
					prod1_q <= dbx * dpy;
					prod2_q <= dby * dpx;
					if (job_q != 2'd0) begin
						dx_q[ej] <= dbx;
						dy_q[ej] <= -dby;
					end
					state_q <= SU_SUB;
				end
				SU_SUB: begin
					if (job_q == 2'd0)
						area_q <= edge_w;
					else
						row_w_q[ej] <= edge_w;
					if (job_q == 2'd3) begin
						state_q <= SU_IDLE;
					end else begin
						job_q   <= job_q + 2'd1;
						state_q <= SU_MUL;
					end
				end
				default: state_q <= SU_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign area  = area_q;
	assign box   = box_q;
	assign row_w = row_w_q;
	assign dx    = dx_q;
	assign dy    = dy_q;

endmodule

@@ hw/rtl/triangle_edge_rasterizer.sv @@
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer
// Edge-function rasterizer with barycentric colour and texture interpolation.
// ----------------------------------------------------------------------------
// Usage notes
//  - Input channel (in_valid / in_stall): kind 0 loads one corner (slot 0..2,
//    slot 3 is dropped); kind 1 is a tick that yields one pixel result.
//    A transaction is taken only while the engine is idle.
//  - Output channel (out_valid / out_stall): one result per tick, held in an
//    output register; a new input transaction can be taken while it waits.
//  - Corner loads finish in the accept cycle and produce nothing.
//  - The first tick after loads or after a finished scan runs setup through
//    the shared edge multiplier pair (offset, box, then area and each edge weight).
//  - Uncovered pixel: accept, evaluate state, output state, output register.
//  - Covered pixel: five lanes run in parallel, each with a bit-serial
//    weighted sum and then a radix-2 divide.
//  - A stalled receiver holds the result; the engine waits before loading
//    the output register again, nothing is dropped.
//  - Reset clears corners, clip window (full screen) and offsets; no pass.
//  - APB registers at 4*i: clip_left, clip_right, clip_top, clip_bottom,
//    shift_x, shift_y. pready is tied high. Write only while idle.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer #(
	parameter int COORD_BITS  = 11,
	parameter int WEIGHT_BITS = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [1:0]                          corner_slot,
	input  logic signed [COORD_BITS-1:0]        pos_x,
	input  logic signed [COORD_BITS-1:0]        pos_y,
	input  logic [tri_pkg::ATTR_BITS-1:0]       red_in,
	input  logic [tri_pkg::ATTR_BITS-1:0]       green_in,
	input  logic [tri_pkg::ATTR_BITS-1:0]       blue_in,
	input  logic [tri_pkg::ATTR_BITS-1:0]       tex_u_in,
	input  logic [tri_pkg::ATTR_BITS-1:0]       tex_v_in,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tri_pkg::COL_BITS-1:0]        pixel_x,
	output logic [tri_pkg::ROW_BITS-1:0]        pixel_y,
	output logic                                covered,
	output logic [tri_pkg::ATTR_BITS-1:0]       red_out,
	output logic [tri_pkg::ATTR_BITS-1:0]       green_out,
	output logic [tri_pkg::ATTR_BITS-1:0]       blue_out,
	output logic [tri_pkg::ATTR_BITS-1:0]       tex_u_out,
	output logic [tri_pkg::ATTR_BITS-1:0]       tex_v_out,
	output logic                                last
);
	import tri_pkg::*;

	localparam int CW = ((COORD_BITS > SHIFT_BITS) ? COORD_BITS : SHIFT_BITS) + 1;
	localparam int DW = CW + 1;
	localparam int WB = WEIGHT_BITS;

	// register map (word index)
	localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [2:0] REG_CLIP_RIGHT  = 3'd1;
	localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
	localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
	localparam logic [2:0] REG_SHIFT_X     = 3'd4;
	localparam logic [2:0] REG_SHIFT_Y     = 3'd5;

	localparam logic KIND_LOAD = 1'b0;

	typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_EVAL, ST_LANES, ST_OUT} state_t;

	state_t                 state_q;
	clip_cfg_t              cfg_q;
	logic signed [COORD_BITS-1:0] corner_x_q [3];
	logic signed [COORD_BITS-1:0] corner_y_q [3];
	attr_t                  corner_attr_q [3];
	logic signed [WB-1:0]   row_w_q [3];
	logic signed [WB-1:0]   cur_w_q [3];
	logic [COL_BITS-1:0]    col_q;
	logic [ROW_BITS-1:0]    row_q;
	logic                   scan_q;
	logic [COL_BITS-1:0]    pend_col_q;
	logic [ROW_BITS-1:0]    pend_row_q;
	logic                   pend_cov_q, pend_last_q;
	logic                   out_valid_q, out_cov_q, out_last_q;
	logic [COL_BITS-1:0]    out_x_q;
	logic [ROW_BITS-1:0]    out_y_q;
	attr_t                  out_attr_q;

	logic                   accept, cfg_wr, su_start, lane_start, pix_cov, degenerate;
	logic                   su_done, swap;
	logic signed [WB-1:0]   su_area;
	logic [WB-1:0]          abs_area;
	box_t                   su_box;
	logic signed [WB-1:0]   su_row_w [3];
	logic signed [DW-1:0]   su_dx [3];
	logic signed [DW-1:0]   su_dy [3];
	logic [NUM_ATTRS-1:0]   lane_done;
	attr_t                  lane_q;

	assign pready   = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left    <= '0;
			cfg_q.right   <= '1;
			cfg_q.top     <= '0;
			cfg_q.bottom  <= '1;
			cfg_q.shift_x <= '0;
			cfg_q.shift_y <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_CLIP_LEFT:   cfg_q.left    <= pwdata[COL_BITS-1:0];
				REG_CLIP_RIGHT:  cfg_q.right   <= pwdata[COL_BITS-1:0];
				REG_CLIP_TOP:    cfg_q.top     <= pwdata[ROW_BITS-1:0];
				REG_CLIP_BOTTOM: cfg_q.bottom  <= pwdata[ROW_BITS-1:0];
				REG_SHIFT_X:     cfg_q.shift_x <= pwdata[SHIFT_BITS-1:0];
				REG_SHIFT_Y:     cfg_q.shift_y <= pwdata[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_CLIP_LEFT:   prdata = 32'(cfg_q.left);
			REG_CLIP_RIGHT:  prdata = 32'(cfg_q.right);
			REG_CLIP_TOP:    prdata = 32'(cfg_q.top);
			REG_CLIP_BOTTOM: prdata = 32'(cfg_q.bottom);
			REG_SHIFT_X:     prdata = {{(32-SHIFT_BITS){1'b0}}, cfg_q.shift_x};
			REG_SHIFT_Y:     prdata = {{(32-SHIFT_BITS){1'b0}}, cfg_q.shift_y};
			default:         prdata = '0;
		endcase
	end

	// --------------------------------------------------------------- corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORNERS; i++) begin
				corner_x_q[i]    <= '0;
				corner_y_q[i]    <= '0;
				corner_attr_q[i] <= '0;
			end
		end else if (accept && kind == KIND_LOAD && corner_slot < 2'(NUM_CORNERS)) begin
			corner_x_q[corner_slot]    <= pos_x;
			corner_y_q[corner_slot]    <= pos_y;
			corner_attr_q[corner_slot] <= {tex_v_in, tex_u_in, blue_in, green_in, red_in};
		end
	end

	// ----------------------------------------------------------------- setup
	assign su_start = accept && kind != KIND_LOAD && !scan_q;

	tri_setup #(
		.COORD_BITS  (COORD_BITS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (su_start),
		.cx     (corner_x_q),
		.cy     (corner_y_q),
		.cfg    (cfg_q),
		.done   (su_done),
		.area   (su_area),
		.box    (su_box),
		.row_w  (su_row_w),
		.dx     (su_dx),
		.dy     (su_dy)
	);

	assign swap       = su_area[WB-1];
	assign abs_area   = swap ? unsigned'(-su_area) : unsigned'(su_area);
	assign degenerate = (su_area == '0) || (su_box.min_col > su_box.max_col)
		|| (su_box.min_row > su_box.max_row);
	assign pix_cov    = !cur_w_q[0][WB-1] && !cur_w_q[1][WB-1] && !cur_w_q[2][WB-1];
	assign lane_start = (state_q == ST_EVAL) && pix_cov;

	// ----------------------------------------------------------------- lanes
	// attribute of role a pairs with the weight of edge b-c, and so on
	for (genvar f = 0; f < NUM_ATTRS; f++) begin : g_lane
		logic [ATTR_BITS-1:0] att_a, att_b;
		assign att_a = swap ? corner_attr_q[1][f] : corner_attr_q[0][f];
		assign att_b = swap ? corner_attr_q[0][f] : corner_attr_q[1][f];

		tri_lane #(
			.WEIGHT_BITS (WEIGHT_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.a0     (att_a),
			.a1     (att_b),
			.a2     (corner_attr_q[2][f]),
			.w0     (unsigned'(cur_w_q[1])),
			.w1     (unsigned'(cur_w_q[2])),
			.w2     (unsigned'(cur_w_q[0])),
			.area   (abs_area),
			.quot   (lane_q[f]),
			.done   (lane_done[f])
		);
	end

	// ------------------------------------------------------------ scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			pend_col_q  <= '0;
			pend_row_q  <= '0;
			pend_cov_q  <= 1'b0;
			pend_last_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_cov_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_attr_q  <= '0;
			for (int e = 0; e < NUM_CORNERS; e++) begin
				row_w_q[e] <= '0;
				cur_w_q[e] <= '0;
			end
		end else begin
			// ST_OUT reloads the register itself
			if (out_valid_q && !out_stall && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_LOAD) begin
							if (corner_slot < 2'(NUM_CORNERS))
								scan_q <= 1'b0;
						end else if (scan_q) begin
							state_q <= ST_EVAL;
						end else begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					if (su_done) begin
						for (int e = 0; e < NUM_CORNERS; e++) begin
							row_w_q[e] <= su_row_w[e];
							cur_w_q[e] <= su_row_w[e];
						end
						col_q <= su_box.min_col;
						row_q <= su_box.min_row;
						if (degenerate) begin
							// zero area or empty box: one uncovered last pixel
							pend_col_q  <= su_box.min_col;
							pend_row_q  <= su_box.min_row;
							pend_cov_q  <= 1'b0;
							pend_last_q <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							scan_q  <= 1'b1;
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					pend_col_q  <= col_q;
					pend_row_q  <= row_q;
					pend_cov_q  <= pix_cov;
					pend_last_q <= (col_q >= su_box.max_col) && (row_q >= su_box.max_row);
					// lanes latch the weights now, so stepping can go ahead
					if (col_q >= su_box.max_col) begin
						if (row_q >= su_box.max_row) begin
							scan_q <= 1'b0;
						end else begin
							for (int e = 0; e < NUM_CORNERS; e++) begin
								row_w_q[e] <= row_w_q[e] + WB'(su_dx[e]);
								cur_w_q[e] <= row_w_q[e] + WB'(su_dx[e]);
							end
							col_q <= su_box.min_col;
							row_q <= row_q + 1'b1;
						end
					end else begin
						for (int e = 0; e < NUM_CORNERS; e++)
							cur_w_q[e] <= cur_w_q[e] + WB'(su_dy[e]);
						col_q <= col_q + 1'b1;
					end
					state_q <= pix_cov ? ST_LANES : ST_OUT;
				end
				ST_LANES: begin
					if (lane_done[0])
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_x_q     <= pend_col_q;
						out_y_q     <= pend_row_q;
						out_cov_q   <= pend_cov_q;
						out_last_q  <= pend_last_q;
						out_attr_q  <= pend_cov_q ? lane_q : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = out_x_q;
	assign pixel_y   = out_y_q;
	assign covered   = out_cov_q;
	assign last      = out_last_q;
	assign red_out   = out_attr_q[ATTR_RED];
	assign green_out = out_attr_q[ATTR_GREEN];
	assign blue_out  = out_attr_q[ATTR_BLUE];
	assign tex_u_out = out_attr_q[ATTR_TEX_U];
	assign tex_v_out = out_attr_q[ATTR_TEX_V];

`ifndef SYNTH
	// a running scan always has a non-empty box
	a_scan_box: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q |-> (su_box.min_col <= su_box.max_col && su_box.min_row <= su_box.max_row))
		else $error("scan active on empty box");

	// the cursor never leaves the box while scanning
	a_cursor_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q |-> (col_q >= su_box.min_col && col_q <= su_box.max_col
			&& row_q >= su_box.min_row && row_q <= su_box.max_row))
		else $error("cursor outside box");

	// uncovered results carry zero attributes
	a_uncov_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_cov_q) |-> (out_attr_q == '0))
		else $error("uncovered pixel with attributes");

	// lanes only finish while the engine waits for them
	a_lane_state: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (state_q == ST_LANES))
		else $error("lane done outside lane wait");
`endif

endmodule

@@ tb/sv/raster_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// raster_tb_pkg
// Register map of the rasterizer as the testbench sees it.
// ----------------------------------------------------------------------------
package raster_tb_pkg;

	typedef enum logic [2:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_RIGHT  = 3'd1,
		REG_CLIP_TOP    = 3'd2,
		REG_CLIP_BOTTOM = 3'd3,
		REG_SHIFT_X     = 3'd4,
		REG_SHIFT_Y     = 3'd5
	} raster_reg_e;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

endpackage

@@ tb/sv/raster_scoreboard.sv @@
// ----------------------------------------------------------------------------
// raster_scoreboard
// Watches the config port and both channels, predicts every pixel and
// compares it with what the rasterizer emits.
// ----------------------------------------------------------------------------
module raster_scoreboard
	import tri_pkg::*;
	import raster_tb_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [4:0]                 paddr,
	input  logic [31:0]                pwdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       kind,
	input  logic [1:0]                 corner_slot,
	input  logic signed [10:0]         pos_x,
	input  logic signed [10:0]         pos_y,
	input  logic [ATTR_BITS-1:0]       red_in,
	input  logic [ATTR_BITS-1:0]       green_in,
	input  logic [ATTR_BITS-1:0]       blue_in,
	input  logic [ATTR_BITS-1:0]       tex_u_in,
	input  logic [ATTR_BITS-1:0]       tex_v_in,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [COL_BITS-1:0]        pixel_x,
	input  logic [ROW_BITS-1:0]        pixel_y,
	input  logic                       covered,
	input  logic [ATTR_BITS-1:0]       red_out,
	input  logic [ATTR_BITS-1:0]       green_out,
	input  logic [ATTR_BITS-1:0]       blue_out,
	input  logic [ATTR_BITS-1:0]       tex_u_out,
	input  logic [ATTR_BITS-1:0]       tex_v_out,
	input  logic                       last,
	output int                         pending,
	output int                         failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [COL_BITS-1:0]  x;
		logic [ROW_BITS-1:0]  y;
		logic                 cov;
		logic [ATTR_BITS-1:0] attr [NUM_ATTRS];
		logic                 fin;
	} pixel_t;

	pixel_t pixel_q [$];

	longint clip_l, clip_r, clip_t, clip_b, off_x, off_y;
	longint vx [3], vy [3];
	logic [ATTR_BITS-1:0] vattr [3][NUM_ATTRS];
	longint row_w [3], cur_w [3], area2;
	longint box [4];
	longint col, row;
	bit scanning;

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint edge_w(longint ax, longint ay, longint bx, longint by,
			longint px, longint py);
		return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
	endfunction

	// counter-clockwise corner order: clockwise input swaps corners 0 and 1
	function automatic int role(int e);
		if (e == 2) return 2;
		return (area2 < 0) ? 1 - e : e;
	endfunction

	task automatic setup_scan();
		longint sx [3], sy [3];
		longint mnx, mxx, mny, mxy;
		int a, b;
		for (int i = 0; i < 3; i++) begin
			sx[i] = vx[i] + off_x;
			sy[i] = vy[i] + off_y;
		end
		area2 = edge_w(sx[0], sy[0], sx[1], sy[1], sx[2], sy[2]);
		mnx = sx[0]; mxx = sx[0]; mny = sy[0]; mxy = sy[0];
		for (int i = 1; i < 3; i++) begin
			if (sx[i] < mnx) mnx = sx[i];
			if (sx[i] > mxx) mxx = sx[i];
			if (sy[i] < mny) mny = sy[i];
			if (sy[i] > mxy) mxy = sy[i];
		end
		box[0] = clamp(mnx, clip_l, clip_r);
		box[1] = clamp(mxx, clip_l, clip_r);
		box[2] = clamp(mny, clip_t, clip_b);
		box[3] = clamp(mxy, clip_t, clip_b);
		for (int e = 0; e < 3; e++) begin
			a = role(e);
			b = role((e + 1) % 3);
			row_w[e] = edge_w(sx[a], sy[a], sx[b], sy[b], box[0], box[2]);
			cur_w[e] = row_w[e];
		end
		col = box[0];
		row = box[2];
	endtask

	task automatic predict_tick();
		pixel_t p;
		longint mag, num;
		int a, b;
		p.cov = 1'b0;
		p.fin = 1'b0;
		for (int f = 0; f < NUM_ATTRS; f++) p.attr[f] = '0;
		if (!scanning) begin
			setup_scan();
			if (area2 == 0 || box[0] > box[1] || box[2] > box[3]) begin
				// degenerate or empty box: one uncovered pixel flagged last
				p.x = COL_BITS'(col);
				p.y = ROW_BITS'(row);
				p.fin = 1'b1;
				pixel_q.push_back(p);
				return;
			end
			scanning = 1;
		end
		p.x = COL_BITS'(col);
		p.y = ROW_BITS'(row);
		if (cur_w[0] >= 0 && cur_w[1] >= 0 && cur_w[2] >= 0) begin
			mag = (area2 < 0) ? -area2 : area2;
			p.cov = 1'b1;
			for (int f = 0; f < NUM_ATTRS; f++) begin
				num = longint'(vattr[role(0)][f]) * cur_w[1] +
					longint'(vattr[role(1)][f]) * cur_w[2] +
					longint'(vattr[role(2)][f]) * cur_w[0];
				p.attr[f] = ATTR_BITS'(clamp(num / mag, 0, 255));
			end
		end
		if (col >= box[1]) begin
			if (row >= box[3]) begin
				p.fin = 1'b1;
				scanning = 0;
			end else begin
				for (int e = 0; e < 3; e++) begin
					a = role(e);
					b = role((e + 1) % 3);
					row_w[e] += vx[b] - vx[a];
					cur_w[e] = row_w[e];
				end
				col = box[0];
				row = (row + 1) & 'h1FF;
			end
		end else begin
			for (int e = 0; e < 3; e++) begin
				a = role(e);
				b = role((e + 1) % 3);
				cur_w[e] += vy[a] - vy[b];
			end
			col = (col + 1) & 'h3FF;
		end
		pixel_q.push_back(p);
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			failures++;
			if (failures <= 10)
				$display("%0t: pixel %s expected %0d got %0d", $realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		if (!arst_n) begin
			clip_l = 0; clip_r = 1023; clip_t = 0; clip_b = 511;
			off_x = 0; off_y = 0;
			for (int i = 0; i < 3; i++) begin
				vx[i] = 0; vy[i] = 0; row_w[i] = 0; cur_w[i] = 0;
				for (int f = 0; f < NUM_ATTRS; f++) vattr[i][f] = '0;
			end
			for (int i = 0; i < 4; i++) box[i] = 0;
			area2 = 0; col = 0; row = 0; scanning = 0;
			pixel_q.delete();
			failures = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (raster_reg_e'(paddr[4:2]))
					REG_CLIP_LEFT:   clip_l = longint'(pwdata[9:0]);
					REG_CLIP_RIGHT:  clip_r = longint'(pwdata[9:0]);
					REG_CLIP_TOP:    clip_t = longint'(pwdata[8:0]);
					REG_CLIP_BOTTOM: clip_b = longint'(pwdata[8:0]);
					REG_SHIFT_X:     off_x = longint'($signed(pwdata[10:0]));
					REG_SHIFT_Y:     off_y = longint'($signed(pwdata[10:0]));
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: pixel (%0d,%0d) with none expected",
							$realtime, pixel_x, pixel_y);
				end else begin
					e = pixel_q.pop_front();
					check_field("x", e.x, pixel_x);
					check_field("y", e.y, pixel_y);
					check_field("covered", e.cov, covered);
					check_field("red", e.attr[ATTR_RED], red_out);
					check_field("green", e.attr[ATTR_GREEN], green_out);
					check_field("blue", e.attr[ATTR_BLUE], blue_out);
					check_field("tex_u", e.attr[ATTR_TEX_U], tex_u_out);
					check_field("tex_v", e.attr[ATTR_TEX_V], tex_v_out);
					check_field("last", e.fin, last);
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_TICK) predict_tick();
				else if (corner_slot < 2'd3) begin
					vx[corner_slot] = longint'(pos_x);
					vy[corner_slot] = longint'(pos_y);
					vattr[corner_slot][ATTR_RED]   = red_in;
					vattr[corner_slot][ATTR_GREEN] = green_in;
					vattr[corner_slot][ATTR_BLUE]  = blue_in;
					vattr[corner_slot][ATTR_TEX_U] = tex_u_in;
					vattr[corner_slot][ATTR_TEX_V] = tex_v_in;
					scanning = 0;
				end
			end
		end
		pending = pixel_q.size();
	end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the triangle edge rasterizer: directed corner
// cases, then random triangles scanned under changing clip windows and
// drawing offsets, with random idling on both channels. Checking is done
// by raster_scoreboard.
// ----------------------------------------------------------------------------
module tb;
	import tri_pkg::*;
	import raster_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;

	// config port
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// input channel
	logic                  in_valid = 0;
	logic                  in_stall;
	logic                  kind = 0;
	logic [1:0]            corner_slot = '0;
	logic signed [10:0]    pos_x = '0, pos_y = '0;
	logic [ATTR_BITS-1:0]  red_in = '0, green_in = '0, blue_in = '0;
	logic [ATTR_BITS-1:0]  tex_u_in = '0, tex_v_in = '0;

	// output channel
	logic                  out_valid;
	logic                  out_stall = 1;
	logic [COL_BITS-1:0]   pixel_x;
	logic [ROW_BITS-1:0]   pixel_y;
	logic                  covered, last;
	logic [ATTR_BITS-1:0]  red_out, green_out, blue_out, tex_u_out, tex_v_out;

	int  pending, failures;
	int  sent = 0;       // transactions accepted on the input channel
	bit  calm = 0;       // no idling on either side while set
	bit  held_off = 0;   // long receiver hold-off already done

	// shadow of the clip window, used to aim triangles at the visible area
	int cl = 0, cr = 1023, ct = 0, cb = 511, ox = 0, oy = 0;

	always #1 clk = ~clk;

	triangle_edge_rasterizer i_dut (.*);

	raster_scoreboard i_score (.*);

	// Run limit: far above the slowest legal run (every tick's work plus
	// stalls on both sides and the long hold-off).
	initial begin
		#2_000_000;
		$display("triangle_edge_rasterizer: mismatch");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off so the result register
	// fills and the block pushes back on the input side.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && sent > 300) begin
				held_off = 1;
				out_stall <= 1;
				repeat (400) @(negedge clk);
			end else
				out_stall <= !calm && ($urandom_range(99) < 31);
		end
	end

	task automatic cfg_write(raster_reg_e idx, int value);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Drain: stop offering, wait for every pixel, then idle before returning,
	// since loads produce nothing to wait on.
	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_clip(int l, int r, int t, int b, int sx, int sy);
		drain();
		cfg_write(REG_CLIP_LEFT, l);
		cfg_write(REG_CLIP_RIGHT, r);
		cfg_write(REG_CLIP_TOP, t);
		cfg_write(REG_CLIP_BOTTOM, b);
		cfg_write(REG_SHIFT_X, sx);
		cfg_write(REG_SHIFT_Y, sy);
		cl = l; cr = r; ct = t; cb = b; ox = sx; oy = sy;
	endtask

	// One transaction on the input channel; returns once accepted.
	task automatic send(logic k, logic [1:0] slot, int x, int y,
			logic [39:0] attrs);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		kind <= k;
		corner_slot <= slot;
		pos_x <= 11'(x);
		pos_y <= 11'(y);
		{tex_v_in, tex_u_in, blue_in, green_in, red_in} <= attrs;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic corner(logic [1:0] slot, int x, int y);
		send(KIND_LOAD, slot, x, y, {$urandom, $urandom});
	endtask

	task automatic ticks(int n);
		for (int i = 0; i < n; i++)
			send(KIND_TICK, $urandom_range(3), $urandom, $urandom, {$urandom, $urandom});
	endtask

	function automatic int lim(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// Small random triangle; mostly placed inside the current window.
	task automatic random_triangle();
		int bx, by, n;
		if ($urandom_range(9) < 7) begin
			bx = lim(int'($urandom_range(cr > cl ? cr - cl : 0)) + cl - ox - 2, -1024, 1015);
			by = lim(int'($urandom_range(cb > ct ? cb - ct : 0)) + ct - oy - 2, -1024, 1015);
		end else begin
			bx = int'($urandom_range(2039)) - 1024;
			by = int'($urandom_range(2039)) - 1024;
		end
		for (int s = 0; s < 3; s++)
			corner(s, bx + int'($urandom_range(7)), by + int'($urandom_range(7)));
		n = $urandom_range(1, 50);
		ticks(n);
	endtask

	initial begin
		int extremes [4];
		repeat (7) @(negedge clk);
		arst_n = 1;

		// directed: ignored slot, attribute extremes, both windings
		corner(2'd3, 1023, -1024);
		send(KIND_LOAD, 2'd0, 10, 10, '0);
		send(KIND_LOAD, 2'd1, 14, 10, '1);
		send(KIND_LOAD, 2'd2, 10, 14, 40'h00FF_80FF_00);
		ticks(6);
		corner(2'd1, 10, 14);                 // now clockwise
		corner(2'd2, 14, 10);
		ticks(4);
		corner(2'd2, 18, 18);                 // collinear: zero area
		corner(2'd1, 14, 14);
		ticks(1);
		// position extremes, box clipped to the screen
		corner(2'd0, -1024, -1024);
		corner(2'd1, 1023, 0);
		corner(2'd2, 0, 1023);
		ticks(3);

		// inverted window: empty box
		set_clip(900, 100, 400, 50, 0, 0);
		ticks(2);
		// offset extremes push everything against the edges
		set_clip(0, 1023, 0, 511, 1023, -1024);
		random_triangle();
		set_clip(0, 1023, 0, 511, -1024, 1023);
		random_triangle();
		set_clip(1023, 1023, 511, 511, 0, 0);
		random_triangle();

		while (sent < 900) begin
			if ($urandom_range(3) == 0) begin
				extremes[0] = $urandom_range(1023);
				extremes[1] = $urandom_range(1023);
				extremes[2] = $urandom_range(511);
				extremes[3] = $urandom_range(511);
				set_clip(extremes[0], extremes[1] | 10'h200 * $urandom_range(1),
					extremes[2], extremes[3] | 9'h100 * $urandom_range(1),
					int'($urandom_range(2047)) - 1024, int'($urandom_range(2047)) - 1024);
			end else if ($urandom_range(2) == 0)
				set_clip($urandom_range(50), 1023 - $urandom_range(50), $urandom_range(50),
					511 - $urandom_range(50), int'($urandom_range(40)) - 20,
					int'($urandom_range(40)) - 20);
			for (int t = 0; t < 6; t++) begin
				calm = (sent >= 500 && sent < 620);
				if ($urandom_range(9) == 0) begin
					// noise: a stray load in any slot, or a bare tick
					if ($urandom_range(1)) corner($urandom_range(3), $urandom, $urandom);
					else ticks(1);
				end else
					random_triangle();
			end
		end
		calm = 0;
		@(negedge clk);
		in_valid <= 0;

		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (failures == 0)
			$display("triangle_edge_rasterizer: match");
		else
			$display("triangle_edge_rasterizer: mismatch");
		$finish;
	end

endmodule
